// ----- sv/kmht_pkg.sv -----
`default_nettype none
package kmht_pkg;

  localparam int unsigned HEAP_DEPTH_DEF = 64;
  localparam int unsigned ID_COUNT_DEF   = 1024;
  localparam int unsigned TIME_WIDTH_DEF = 32;

  localparam int unsigned ID_W      = 10;
  localparam int unsigned TIMEOUT_W = 20;
  localparam int unsigned NOW_W     = 32;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned STAT_W    = 3;
  localparam int unsigned IDX_EXT_W = 17;

  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [ACT_W-1:0] ACT_ADD    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADJUST = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TICK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STAT_W-1:0] ST_EXPIRED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NONE      = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

  localparam int unsigned OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
  localparam logic [OP_W-1:0] OP_SET_UPD  = 4'd2;
  localparam logic [OP_W-1:0] OP_SET_ADD  = 4'd3;
  localparam logic [OP_W-1:0] OP_REM_DEL  = 4'd4;
  localparam logic [OP_W-1:0] OP_REM_TICK = 4'd5;
  localparam logic [OP_W-1:0] OP_REM_LD   = 4'd6;
  localparam logic [OP_W-1:0] OP_SD_READ  = 4'd7;
  localparam logic [OP_W-1:0] OP_SD_A     = 4'd8;
  localparam logic [OP_W-1:0] OP_SD_B     = 4'd9;
  localparam logic [OP_W-1:0] OP_SD_MOVE  = 4'd10;
  localparam logic [OP_W-1:0] OP_SU_READ  = 4'd11;
  localparam logic [OP_W-1:0] OP_SU_MOVE  = 4'd12;
  localparam logic [OP_W-1:0] OP_FINAL    = 4'd13;
  localparam logic [OP_W-1:0] OP_TICK_RD  = 4'd14;
  localparam logic [OP_W-1:0] OP_CLR_STEP = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              clr_init;
    logic              emit;
    logic [STAT_W-1:0] emit_status;
    logic              emit_last;
    logic              emit_pend;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic known;
    logic id_oob;
    logic full;
    logic c_in;
    logic has_right;
    logic at_zero;
    logic stop_down;
    logic stop_up;
    logic moved;
    logic expire;
    logic occ_zero;
    logic need_swap;
    logic cnt_max;
    logic cnt_zero;
    logic sweep_done;
  } sts_t;

endpackage
`default_nettype wire

// ----- sv/kmht_ram.sv -----
`default_nettype none
module kmht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- sv/kmht_ctrl.sv -----
`default_nettype none
module kmht_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire kmht_pkg::sts_t sts_i,
  output kmht_pkg::cmd_t      cmd_o
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DEC    = 4'd2;
  localparam logic [3:0] S_REMCHK = 4'd3;
  localparam logic [3:0] S_SDCHK  = 4'd4;
  localparam logic [3:0] S_SDA    = 4'd5;
  localparam logic [3:0] S_SDB    = 4'd6;
  localparam logic [3:0] S_SDST   = 4'd7;
  localparam logic [3:0] S_SUCHK  = 4'd8;
  localparam logic [3:0] S_SUEV   = 4'd9;
  localparam logic [3:0] S_TCHK   = 4'd10;
  localparam logic [3:0] S_TEVAL  = 4'd11;

  logic [3:0] state_q, state_d;
  logic       emit_clr_q, emit_clr_d;
  logic       is_tick;

  assign busy    = (state_q != S_IDLE);
  assign is_tick = (sts_i.act == kmht_pkg::ACT_TICK);

  always_comb begin
    state_d    = state_q;
    emit_clr_d = emit_clr_q;
    cmd_o      = '0;
    cmd_o.op   = kmht_pkg::OP_NONE;

    case (state_q)
      S_CLR: begin
        cmd_o.op = kmht_pkg::OP_CLR_STEP;
        if (sts_i.sweep_done) begin
          state_d = S_IDLE;
          if (emit_clr_q) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = kmht_pkg::ST_DONE;
            cmd_o.emit_last   = 1'b1;
          end
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.op = kmht_pkg::OP_LOAD;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        state_d         = S_IDLE;
        cmd_o.emit      = 1'b1;
        cmd_o.emit_last = 1'b1;
        case (sts_i.act)
          kmht_pkg::ACT_ADD: begin
            if (sts_i.id_oob) begin
              cmd_o.emit_status = kmht_pkg::ST_NOT_FOUND;
            end else if (sts_i.known) begin
              cmd_o.emit = 1'b0;
              cmd_o.op   = kmht_pkg::OP_SET_UPD;
              state_d    = S_SDCHK;
            end else if (sts_i.full) begin
              cmd_o.emit_status = kmht_pkg::ST_FULL;
            end else begin
              cmd_o.emit = 1'b0;
              cmd_o.op   = kmht_pkg::OP_SET_ADD;
              state_d    = S_SUCHK;
            end
          end
          kmht_pkg::ACT_ADJUST: begin
            if (sts_i.known) begin
              cmd_o.emit = 1'b0;
              cmd_o.op   = kmht_pkg::OP_SET_UPD;
              state_d    = S_SDCHK;
            end else begin
              cmd_o.emit_status = kmht_pkg::ST_NOT_FOUND;
            end
          end
          kmht_pkg::ACT_DELETE: begin
            if (sts_i.known) begin
              cmd_o.emit = 1'b0;
              cmd_o.op   = kmht_pkg::OP_REM_DEL;
              state_d    = S_REMCHK;
            end else begin
              cmd_o.emit_status = kmht_pkg::ST_NOT_FOUND;
            end
          end
          kmht_pkg::ACT_TICK: begin
            cmd_o.emit = 1'b0;
            state_d    = S_TCHK;
          end
          kmht_pkg::ACT_CLEAR: begin
            cmd_o.emit     = 1'b0;
            cmd_o.clr_init = 1'b1;
            emit_clr_d     = 1'b1;
            state_d        = S_CLR;
          end
          default: begin
            cmd_o.emit_status = kmht_pkg::ST_DONE;
          end
        endcase
      end
      S_REMCHK: begin
        if (sts_i.need_swap) begin
          cmd_o.op = kmht_pkg::OP_REM_LD;
          state_d  = S_SDCHK;
        end else if (is_tick) begin
          state_d = S_TCHK;
        end else begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_SDCHK: begin
        if (sts_i.c_in) begin
          cmd_o.op = kmht_pkg::OP_SD_READ;
          state_d  = S_SDA;
        end else if (sts_i.moved) begin
          cmd_o.op = kmht_pkg::OP_FINAL;
          if (is_tick) begin
            state_d = S_TCHK;
          end else begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_last = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          state_d = S_SUCHK;
        end
      end
      S_SDA: begin
        cmd_o.op = kmht_pkg::OP_SD_A;
        state_d  = sts_i.has_right ? S_SDB : S_SDST;
      end
      S_SDB: begin
        cmd_o.op = kmht_pkg::OP_SD_B;
        state_d  = S_SDST;
      end
      S_SDST: begin
        if (!sts_i.stop_down) begin
          cmd_o.op = kmht_pkg::OP_SD_MOVE;
          state_d  = S_SDCHK;
        end else if (sts_i.moved) begin
          cmd_o.op = kmht_pkg::OP_FINAL;
          if (is_tick) begin
            state_d = S_TCHK;
          end else begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_last = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          state_d = S_SUCHK;
        end
      end
      S_SUCHK: begin
        if (sts_i.at_zero) begin
          cmd_o.op = kmht_pkg::OP_FINAL;
          if (is_tick) begin
            state_d = S_TCHK;
          end else begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_last = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          cmd_o.op = kmht_pkg::OP_SU_READ;
          state_d  = S_SUEV;
        end
      end
      S_SUEV: begin
        if (sts_i.stop_up) begin
          cmd_o.op = kmht_pkg::OP_FINAL;
          if (is_tick) begin
            state_d = S_TCHK;
          end else begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_last = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          cmd_o.op = kmht_pkg::OP_SU_MOVE;
          state_d  = S_SUCHK;
        end
      end
      S_TCHK: begin
        if (sts_i.occ_zero || sts_i.cnt_max) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_pend   = !sts_i.cnt_zero;
          cmd_o.emit_status = sts_i.cnt_zero ? kmht_pkg::ST_NONE : kmht_pkg::ST_EXPIRED;
          state_d           = S_IDLE;
        end else begin
          cmd_o.op = kmht_pkg::OP_TICK_RD;
          state_d  = S_TEVAL;
        end
      end
      S_TEVAL: begin
        if (sts_i.expire) begin
          // previous expired id goes out now that another one follows
          cmd_o.op          = kmht_pkg::OP_REM_TICK;
          cmd_o.emit        = !sts_i.cnt_zero;
          cmd_o.emit_pend   = 1'b1;
          cmd_o.emit_status = kmht_pkg::ST_EXPIRED;
          state_d           = S_REMCHK;
        end else begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_pend   = !sts_i.cnt_zero;
          cmd_o.emit_status = sts_i.cnt_zero ? kmht_pkg::ST_NONE : kmht_pkg::ST_EXPIRED;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      emit_clr_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      emit_clr_q <= (state_q == S_CLR && sts_i.sweep_done) ? 1'b0 : emit_clr_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/kmht_dp.sv -----
`default_nettype none
module kmht_dp #(
  parameter int unsigned HEAP_DEPTH = kmht_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned ID_COUNT   = kmht_pkg::ID_COUNT_DEF,
  parameter int unsigned TIME_WIDTH = kmht_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire kmht_pkg::cmd_t                    cmd_i,
  output kmht_pkg::sts_t                         sts_o,
  input  wire logic [kmht_pkg::ACT_W-1:0]        action_i,
  input  wire logic [kmht_pkg::ID_W-1:0]         timer_id_i,
  input  wire logic [kmht_pkg::TIMEOUT_W-1:0]    timeout_i,
  input  wire logic [kmht_pkg::NOW_W-1:0]        now_i,
  output logic                                   result_valid_o,
  output logic      [kmht_pkg::STAT_W-1:0]       status_o,
  output logic      [kmht_pkg::ID_W-1:0]         expired_id_o,
  output logic                                   last_o
);

  localparam int unsigned SLOTW = $clog2(HEAP_DEPTH);
  localparam int unsigned OCCW  = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned IDW   = $clog2(ID_COUNT);
  localparam int unsigned IW    = kmht_pkg::ID_W;
  localparam int unsigned TW    = TIME_WIDTH;
  localparam int unsigned HW    = IW + TW;
  localparam int unsigned PW    = SLOTW + 1;
  localparam int unsigned SW    = ((TW > kmht_pkg::TIMEOUT_W) ? TW : kmht_pkg::TIMEOUT_W) + 1;
  localparam int unsigned CW    = SLOTW + 2;
  localparam int unsigned XW    = kmht_pkg::IDX_EXT_W;

  logic [kmht_pkg::ACT_W-1:0] act_q;
  logic [IW-1:0]              id_q, cid_q, bid_q, pend_q;
  logic [TW-1:0]              exp_q, now_q, cexp_q, bexp_q;
  logic [SLOTW-1:0]           at_q, c_q;
  logic [OCCW-1:0]            occ_q;
  logic                       moved_q;
  logic [kmht_pkg::CNT_W-1:0] cnt_q;
  logic [IDW-1:0]             sweep_q;

  logic [HW-1:0]    heap_rd, heap_wdata;
  logic [SLOTW-1:0] heap_raddr, heap_waddr;
  logic             heap_re, heap_we;
  logic [PW-1:0]    pos_rd, pos_wdata;
  logic [IDW-1:0]   pos_raddr, pos_waddr;
  logic             pos_re, pos_we;

  logic [IW-1:0]  rd_id;
  logic [TW-1:0]  rd_exp;
  logic [63:0]    now_ext;
  logic [TW-1:0]  now_m, exp_calc;
  logic [SW-1:0]  exp_sum;
  logic [XW-1:0]  in_idx_ext;
  logic [SLOTW-1:0] slot;
  logic [CW-1:0]  left_c, right_c, occ_c;

  function automatic logic [IDW-1:0] idx_of(input logic [IW-1:0] id);
    logic [XW-1:0] ext;
    ext = XW'(id);
    return ext[IDW-1:0];
  endfunction

  assign rd_id  = heap_rd[HW-1:TW];
  assign rd_exp = heap_rd[TW-1:0];
  assign slot   = pos_rd[SLOTW-1:0];

  // expiry saturates at the top of the time range
  assign now_ext  = 64'(now_i);
  assign now_m    = now_ext[TW-1:0];
  assign exp_sum  = SW'(now_m) + SW'(timeout_i);
  assign exp_calc = (|exp_sum[SW-1:TW]) ? '1 : exp_sum[TW-1:0];
  assign in_idx_ext = XW'(id_q);

  assign left_c  = CW'({at_q, 1'b1});
  assign right_c = left_c + CW'(1);
  assign occ_c   = CW'(occ_q);

  always_comb begin
    sts_o            = '0;
    sts_o.act        = act_q;
    sts_o.id_oob     = (in_idx_ext >= XW'(ID_COUNT));
    sts_o.known      = pos_rd[SLOTW] && !sts_o.id_oob && (CW'(slot) < occ_c);
    sts_o.full       = (occ_q >= OCCW'(HEAP_DEPTH));
    sts_o.c_in       = (left_c < occ_c);
    sts_o.has_right  = (right_c < occ_c);
    sts_o.at_zero    = (at_q == '0);
    sts_o.stop_down  = (bexp_q > cexp_q);
    sts_o.stop_up    = (rd_exp < cexp_q);
    sts_o.moved      = moved_q;
    sts_o.expire     = (rd_exp <= now_q);
    sts_o.occ_zero   = (occ_q == '0);
    sts_o.need_swap  = (CW'(at_q) < occ_c);
    sts_o.cnt_max    = (cnt_q == kmht_pkg::CNT_W'(kmht_pkg::MAX_RESULTS));
    sts_o.cnt_zero   = (cnt_q == '0);
    sts_o.sweep_done = (sweep_q == IDW'(ID_COUNT - 1));
  end

  always_comb begin
    heap_re    = 1'b0;
    heap_raddr = '0;
    heap_we    = 1'b0;
    heap_waddr = at_q;
    heap_wdata = {cid_q, cexp_q};
    pos_re     = 1'b0;
    pos_raddr  = idx_of(timer_id_i);
    pos_we     = 1'b0;
    pos_waddr  = idx_of(cid_q);
    pos_wdata  = {1'b1, at_q};
    case (cmd_i.op)
      kmht_pkg::OP_LOAD: begin
        pos_re = 1'b1;
      end
      kmht_pkg::OP_REM_DEL: begin
        heap_re    = 1'b1;
        heap_raddr = SLOTW'(occ_q - OCCW'(1));
        pos_we     = 1'b1;
        pos_waddr  = idx_of(id_q);
        pos_wdata  = '0;
      end
      kmht_pkg::OP_REM_TICK: begin
        heap_re    = 1'b1;
        heap_raddr = SLOTW'(occ_q - OCCW'(1));
        pos_we     = 1'b1;
        pos_waddr  = idx_of(rd_id);
        pos_wdata  = '0;
      end
      kmht_pkg::OP_SD_READ: begin
        heap_re    = 1'b1;
        heap_raddr = left_c[SLOTW-1:0];
      end
      kmht_pkg::OP_SD_A: begin
        heap_re    = 1'b1;
        heap_raddr = right_c[SLOTW-1:0];
      end
      kmht_pkg::OP_SD_MOVE: begin
        heap_we    = 1'b1;
        heap_wdata = {bid_q, bexp_q};
        pos_we     = 1'b1;
        pos_waddr  = idx_of(bid_q);
      end
      kmht_pkg::OP_SU_READ: begin
        heap_re    = 1'b1;
        heap_raddr = (at_q - SLOTW'(1)) >> 1;
      end
      kmht_pkg::OP_SU_MOVE: begin
        heap_we    = 1'b1;
        heap_wdata = heap_rd;
        pos_we     = 1'b1;
        pos_waddr  = idx_of(rd_id);
      end
      kmht_pkg::OP_FINAL: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
      end
      kmht_pkg::OP_TICK_RD: begin
        heap_re = 1'b1;
      end
      kmht_pkg::OP_CLR_STEP: begin
        pos_we    = 1'b1;
        pos_waddr = sweep_q;
        pos_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  kmht_ram #(.WIDTH(HW), .DEPTH(HEAP_DEPTH)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_waddr),
    .wdata_i (heap_wdata),
    .re_i    (heap_re),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rd)
  );

  // position of each id, with its present bit on top
  kmht_ram #(.WIDTH(PW), .DEPTH(ID_COUNT)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .re_i    (pos_re),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rd)
  );

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      kmht_pkg::OP_LOAD: begin
        act_q <= action_i;
        id_q  <= timer_id_i;
        exp_q <= exp_calc;
        now_q <= now_m;
      end
      kmht_pkg::OP_SET_UPD: begin
        cid_q  <= id_q;
        cexp_q <= exp_q;
        at_q   <= slot;
      end
      kmht_pkg::OP_SET_ADD: begin
        cid_q  <= id_q;
        cexp_q <= exp_q;
        at_q   <= SLOTW'(occ_q);
      end
      kmht_pkg::OP_REM_DEL: begin
        at_q <= slot;
      end
      kmht_pkg::OP_REM_TICK: begin
        at_q   <= '0;
        pend_q <= rd_id;
      end
      kmht_pkg::OP_REM_LD: begin
        cid_q  <= rd_id;
        cexp_q <= rd_exp;
      end
      kmht_pkg::OP_SD_A: begin
        bid_q  <= rd_id;
        bexp_q <= rd_exp;
        c_q    <= left_c[SLOTW-1:0];
      end
      kmht_pkg::OP_SD_B: begin
        if (rd_exp < bexp_q) begin
          bid_q  <= rd_id;
          bexp_q <= rd_exp;
          c_q    <= c_q + SLOTW'(1);
        end
      end
      kmht_pkg::OP_SD_MOVE: begin
        at_q <= c_q;
      end
      kmht_pkg::OP_SU_MOVE: begin
        at_q <= (at_q - SLOTW'(1)) >> 1;
      end
      default: begin
      end
    endcase
    status_o     <= cmd_i.emit_status;
    expired_id_o <= cmd_i.emit_pend ? pend_q : '0;
    last_o       <= cmd_i.emit_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q          <= '0;
      moved_q        <= 1'b0;
      cnt_q          <= '0;
      sweep_q        <= '0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.emit;
      if (cmd_i.clr_init) begin
        occ_q   <= '0;
        sweep_q <= '0;
      end
      case (cmd_i.op)
        kmht_pkg::OP_LOAD: begin
          cnt_q <= '0;
        end
        kmht_pkg::OP_SET_UPD: begin
          moved_q <= 1'b0;
        end
        kmht_pkg::OP_SET_ADD: begin
          moved_q <= 1'b0;
          occ_q   <= occ_q + OCCW'(1);
        end
        kmht_pkg::OP_REM_DEL: begin
          occ_q <= occ_q - OCCW'(1);
        end
        kmht_pkg::OP_REM_TICK: begin
          occ_q <= occ_q - OCCW'(1);
          cnt_q <= cnt_q + kmht_pkg::CNT_W'(1);
        end
        kmht_pkg::OP_REM_LD: begin
          moved_q <= 1'b0;
        end
        kmht_pkg::OP_SD_MOVE: begin
          moved_q <= 1'b1;
        end
        kmht_pkg::OP_CLR_STEP: begin
          sweep_q <= sweep_q + IDW'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/keyed_min_heap_timer.sv -----
// add/adjust/delete walk the heap one level at a time (log2 HEAP_DEPTH
// levels at most, one heap memory read and compare per child or parent visited)
// tick: the same walk per expired timer, results one at a time; clear sweeps the id map
// requests: one at a time, next start taken once busy drops
// reset: a sweep over all ID_COUNT ids clears the id map with busy high; results are a
// one-cycle strobe and the receiver cannot stall
`default_nettype none
module keyed_min_heap_timer #(
  parameter int unsigned HEAP_DEPTH = kmht_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned ID_COUNT   = kmht_pkg::ID_COUNT_DEF,
  parameter int unsigned TIME_WIDTH = kmht_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [kmht_pkg::ACT_W-1:0]     action_i,
  input  wire logic [kmht_pkg::ID_W-1:0]      timer_id_i,
  input  wire logic [kmht_pkg::TIMEOUT_W-1:0] timeout_i,
  input  wire logic [kmht_pkg::NOW_W-1:0]     now_i,
  output logic                                result_valid_o,
  output logic      [kmht_pkg::STAT_W-1:0]    status_o,
  output logic      [kmht_pkg::ID_W-1:0]      expired_id_o,
  output logic                                last_o
);

  kmht_pkg::cmd_t cmd;
  kmht_pkg::sts_t sts;

  kmht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  kmht_dp #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .ID_COUNT   (ID_COUNT),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (action_i),
    .timer_id_i     (timer_id_i),
    .timeout_i      (timeout_i),
    .now_i          (now_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .expired_id_o   (expired_id_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire
